>>> src/cdsr_pkg.sv
`timescale 1ns / 1ps

package cdsr_pkg;

	localparam int SAMPLES_DEF     = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int AVG_W     = 12;
	localparam int SUM_W     = 16;
	localparam int PAIR_W    = 5;
	localparam int FRAME_LEN = 7;
	localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

	// Frame bytes
	localparam logic [7:0] BYTE_HDR   = 8'h24;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CMD_C = 8'h43;
	localparam logic [7:0] BYTE_CMD_D = 8'h44;
	localparam logic [7:0] BYTE_CMD_P = 8'h50;

	// Item kinds
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_PAIR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONT_ON   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONT_OFF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEM_ON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEM_OFF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PD = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  rx_byte;
		logic [11:0] sample_first;
		logic [11:0] sample_second;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_out;
		logic       last;
		logic       led_on;
		logic       sample_start;
	} result_t;

	// What the front hands to the back for one item
	typedef struct packed {
		logic             report;
		logic [AVG_W-1:0] avg_first;
		logic [AVG_W-1:0] avg_second;
		logic             led_on;
		logic             sample_start;
	} desc_t;

endpackage

>>> src/command_driven_sample_reporter.sv
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// item      item_valid / item_stall      item_t   (command, rx_byte, samples)
// result    result_valid / result_stall  result_t (tx_valid, tx_out, last, led, trigger)
// config    cfg_we                       cfg_index, cfg_data
//
// The front takes one item per cycle while item_stall is low and resolves
// all state in that cycle. The back sends one result per cycle while
// result_stall is low: one per plain item, one per byte of a report frame.
// The descriptor queue (QUEUE_DEPTH deep) lets the front run on while the
// back is still sending a frame; item_stall rises only when it is full.
// Reset loads the register defaults and empties queue and output register.
module command_driven_sample_reporter import cdsr_pkg::*; #(
	parameter int SAMPLES     = SAMPLES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	desc_t front_desc, back_desc;
	logic  q_full, q_not_empty, q_pop, item_fire;

	assign item_stall = q_full;
	assign item_fire  = item_valid && !q_full;

	cdsr_front #(.SAMPLES(SAMPLES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_fire (item_fire),
		.item      (item),
		.desc      (front_desc)
	);

	cdsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_fire),
		.wr_desc   (front_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_desc   (back_desc)
	);

	cdsr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (q_not_empty),
		.desc         (back_desc),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef ASSERT_OFF
	// a report frame leaves without gaps once a byte of it is taken
	a_frame_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.tx_valid && !result.last
		|=> result_valid && result.tx_valid)
		else $error("report frame interrupted");

	// an accepted item passes through a queue slot into an empty output register
	a_item_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |-> ##2 result_valid)
		else $error("accepted item lost on the way to the output");

	// a plain result is a single one with a zero byte
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.tx_valid |-> result.last && result.tx_out == 8'd0)
		else $error("malformed plain result");
`endif

endmodule

>>> src/cdsr_front.sv
`timescale 1ns / 1ps

module cdsr_front import cdsr_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_fire,
	input  item_t                item,
	output desc_t                desc
);

	typedef enum logic [1:0] {POS_HDR, POS_CMD, POS_CR, POS_LF} pos_t;
	typedef enum logic [1:0] {HELD_NONE, HELD_C, HELD_D, HELD_P} held_t;

	localparam int SHIFT = SUM_W + $clog2(SAMPLES);
	localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1)
		/ 64'(SAMPLES));
	localparam logic [PAIR_W-1:0] SAMPLES_P = PAIR_W'(SAMPLES);
	localparam int PROD_W = 2 * SUM_W + 1;

	logic [CFG_W-1:0] cont_on_q, cont_off_q, dem_on_q, dem_off_q, sample_pd_q;

	pos_t              pos_q, pos_n;
	held_t             held_q, held_n;
	logic              mode_q, mode_n;
	logic              req_q, req_n;
	logic              rpend_q, rpend_n;
	logic              led_q, led_n;
	logic [15:0]       led_el_q, led_el_n, led_inc;
	logic [15:0]       smp_el_q, smp_el_n, smp_inc;
	logic [PAIR_W-1:0] pairs_q, pairs_n, pairs_inc;
	logic [SUM_W-1:0]  sum0_q, sum0_n, sum1_q, sum1_n, sum0_add, sum1_add;
	logic [AVG_W-1:0]  avg0_q, avg0_n, avg1_q, avg1_n;
	logic [15:0]       limit;
	logic [PROD_W-1:0] prod0, prod1;
	logic              fired, report;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_on_q   <= 16'd100;
			cont_off_q  <= 16'd300;
			dem_on_q    <= 16'd500;
			dem_off_q   <= 16'd400;
			sample_pd_q <= 16'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONT_ON:   cont_on_q   <= cfg_data;
				REG_CONT_OFF:  cont_off_q  <= cfg_data;
				REG_DEM_ON:    dem_on_q    <= cfg_data;
				REG_DEM_OFF:   dem_off_q   <= cfg_data;
				REG_SAMPLE_PD: sample_pd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign led_inc   = (led_el_q == 16'hFFFF) ? led_el_q : led_el_q + 16'd1;
	assign smp_inc   = (smp_el_q == 16'hFFFF) ? smp_el_q : smp_el_q + 16'd1;
	assign pairs_inc = (pairs_q == '1) ? pairs_q : pairs_q + PAIR_W'(1);
	assign sum0_add  = sum0_q + SUM_W'(item.sample_first);
	assign sum1_add  = sum1_q + SUM_W'(item.sample_second);
	// divide by SAMPLES through a rounded-up reciprocal, exact for 16-bit sums
	assign prod0     = PROD_W'(sum0_add) * PROD_W'(RECIP);
	assign prod1     = PROD_W'(sum1_add) * PROD_W'(RECIP);

	always_comb begin
		if (led_q) begin
			limit = mode_q ? dem_on_q : cont_on_q;
		end else begin
			limit = mode_q ? dem_off_q : cont_off_q;
		end
	end

	always_comb begin
		pos_n    = pos_q;
		held_n   = held_q;
		mode_n   = mode_q;
		req_n    = req_q;
		rpend_n  = rpend_q;
		led_n    = led_q;
		led_el_n = led_el_q;
		smp_el_n = smp_el_q;
		pairs_n  = pairs_q;
		sum0_n   = sum0_q;
		sum1_n   = sum1_q;
		avg0_n   = avg0_q;
		avg1_n   = avg1_q;
		fired    = 1'b0;
		unique case (item.command)
			CMD_TICK: begin
				if (led_inc >= limit) begin
					led_n    = ~led_q;
					led_el_n = '0;
				end else begin
					led_el_n = led_inc;
				end
				if (smp_inc >= sample_pd_q) begin
					smp_el_n = '0;
					fired    = 1'b1;
				end else begin
					smp_el_n = smp_inc;
				end
			end
			CMD_BYTE: begin
				pos_n  = POS_HDR;
				held_n = HELD_NONE;
				if (item.rx_byte == BYTE_HDR) begin
					pos_n = POS_CMD;
				end else begin
					unique case (pos_q)
						POS_CMD: begin
							if (item.rx_byte == BYTE_CMD_C) begin
								held_n = HELD_C;
								pos_n  = POS_CR;
							end else if (item.rx_byte == BYTE_CMD_D) begin
								held_n = HELD_D;
								pos_n  = POS_CR;
							end else if (item.rx_byte == BYTE_CMD_P) begin
								held_n = HELD_P;
								pos_n  = POS_CR;
							end
						end
						POS_CR: begin
							if (item.rx_byte == BYTE_CR) begin
								held_n = held_q;
								pos_n  = POS_LF;
							end
						end
						POS_LF: begin
							if (item.rx_byte == BYTE_LF) begin
								unique case (held_q)
									HELD_C: begin
										mode_n = 1'b0;
										req_n  = 1'b1;
									end
									HELD_D: begin
										mode_n = 1'b1;
										req_n  = 1'b0;
									end
									HELD_P:    req_n = 1'b1;
									HELD_NONE: ;
								endcase
							end
						end
						POS_HDR: ;
					endcase
				end
			end
			CMD_PAIR: begin
				if (pairs_inc >= SAMPLES_P) begin
					avg0_n  = AVG_W'(prod0 >> SHIFT);
					avg1_n  = AVG_W'(prod1 >> SHIFT);
					sum0_n  = '0;
					sum1_n  = '0;
					pairs_n = '0;
					rpend_n = 1'b1;
				end else begin
					sum0_n  = sum0_add;
					sum1_n  = sum1_add;
					pairs_n = pairs_inc;
				end
			end
			default: ;
		endcase
		report = rpend_n & req_n;
		if (report) begin
			rpend_n = 1'b0;
			if (mode_n) begin
				req_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HDR;
			held_q   <= HELD_NONE;
			mode_q   <= 1'b0;
			req_q    <= 1'b1;
			rpend_q  <= 1'b0;
			led_q    <= 1'b1;
			led_el_q <= '0;
			smp_el_q <= '0;
			pairs_q  <= '0;
			sum0_q   <= '0;
			sum1_q   <= '0;
			avg0_q   <= '0;
			avg1_q   <= '0;
		end else if (item_fire) begin
			pos_q    <= pos_n;
			held_q   <= held_n;
			mode_q   <= mode_n;
			req_q    <= req_n;
			rpend_q  <= rpend_n;
			led_q    <= led_n;
			led_el_q <= led_el_n;
			smp_el_q <= smp_el_n;
			pairs_q  <= pairs_n;
			sum0_q   <= sum0_n;
			sum1_q   <= sum1_n;
			avg0_q   <= avg0_n;
			avg1_q   <= avg1_n;
		end
	end

	// averages are taken after this item so a fresh result reports at once
	assign desc.report       = report;
	assign desc.avg_first    = avg0_n;
	assign desc.avg_second   = avg1_n;
	assign desc.led_on       = led_n;
	assign desc.sample_start = fired;

endmodule

>>> src/cdsr_queue.sv
`timescale 1ns / 1ps

module cdsr_queue import cdsr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wr_desc,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output desc_t rd_desc
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	desc_t             slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign rd_desc   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> src/cdsr_back.sv
`timescale 1ns / 1ps

module cdsr_back import cdsr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    desc_valid,
	input  desc_t   desc,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam logic [BYTE_IDX_W-1:0] IDX_LAST = BYTE_IDX_W'(FRAME_LEN - 1);

	desc_t                 cur_q, src;
	logic                  busy_q;
	logic [BYTE_IDX_W-1:0] idx_q, idx;
	logic                  out_valid_q;
	result_t               out_q, res_n;
	logic                  adv, have, more;
	logic [7:0]            frame_byte;

	assign adv  = !out_valid_q || !result_stall;
	assign have = busy_q || desc_valid;
	assign src  = busy_q ? cur_q : desc;
	assign idx  = busy_q ? idx_q : '0;
	assign pop  = adv && !busy_q && desc_valid;
	assign more = src.report && (idx != IDX_LAST);

	always_comb begin
		unique case (idx)
			3'd0:    frame_byte = BYTE_HDR;
			3'd1:    frame_byte = {4'd0, src.avg_first[11:8]};
			3'd2:    frame_byte = src.avg_first[7:0];
			3'd3:    frame_byte = {4'd0, src.avg_second[11:8]};
			3'd4:    frame_byte = src.avg_second[7:0];
			3'd5:    frame_byte = BYTE_CR;
			3'd6:    frame_byte = BYTE_LF;
			default: frame_byte = '0;
		endcase
	end

	always_comb begin
		res_n.tx_valid     = src.report;
		res_n.tx_out       = src.report ? frame_byte : 8'd0;
		res_n.last         = !more;
		res_n.led_on       = src.led_on;
		res_n.sample_start = src.sample_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have) begin
				busy_q <= more;
				idx_q  <= idx + BYTE_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			out_q <= res_n;
			cur_q <= src;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
